FILE: hw/rtl/r2h_pkg.sv
// Shared widths, types and hue sector codes for the RGBA to HWBA converter.
package r2h_pkg;

    localparam int CHAN_W  = 8;
    localparam int HUE_W   = 9;
    localparam int WB_W    = 7;
    localparam int QUO_W   = 6;
    localparam int REM_W   = 15;
    localparam int DVS_W   = 9;
    localparam int SCL_W   = 15;
    localparam int PIX_W   = 32;
    localparam int HWBA_W  = 31;

    localparam logic [HUE_W-1:0] HUE_BASE_RED_UP    = 9'd0;
    localparam logic [HUE_W-1:0] HUE_BASE_GREEN_DN  = 9'd60;
    localparam logic [HUE_W-1:0] HUE_BASE_GREEN_UP  = 9'd120;
    localparam logic [HUE_W-1:0] HUE_BASE_BLUE_DN   = 9'd180;
    localparam logic [HUE_W-1:0] HUE_BASE_BLUE_UP   = 9'd240;
    localparam logic [HUE_W-1:0] HUE_BASE_RED_DN    = 9'd300;
    localparam logic [HUE_W-1:0] HUE_MAX            = 9'd360;

    typedef struct packed {
        logic              grey;
        logic [HUE_W-1:0]  base;
        logic [SCL_W-1:0]  white_scl;
        logic [WB_W-1:0]   white_est;
        logic [SCL_W-1:0]  black_scl;
        logic [WB_W-1:0]   black_est;
        logic [CHAN_W-1:0] alpha;
    } side_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DVS_W-1:0] dvs;
        logic [QUO_W-1:0] quo;
        side_t            side;
    } div_t;

endpackage

FILE: hw/rtl/r2h_div_stage.sv
// One registered restoring-division step that settles one quotient bit of the hue fraction.
module r2h_div_stage
    import r2h_pkg::*;
#(
    parameter int SHIFT = QUO_W - 1
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic valid_in,
    input  div_t data_in,
    output logic valid_out,
    output div_t data_out
);

    logic             valid_reg;
    div_t             data_reg;
    div_t             data_next;
    logic [REM_W-1:0] trial;

    always_comb
    begin
        trial     = REM_W'(data_in.dvs) << SHIFT;
        data_next = data_in;
        if (data_in.rem >= trial)
        begin
            data_next.rem        = data_in.rem - trial;
            data_next.quo[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

    // The remainder left by this step is always below the divisor at this bit weight.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.rem < (REM_W'(data_reg.dvs) << SHIFT)))
        else $error("division remainder out of range");

endmodule

FILE: hw/rtl/rgba_to_hwba_convert.sv
// Top level of the pipelined RGBA to HWBA pixel converter.
//
//  channel   direction  handshake             payload
//  input     in         in_valid / in_stall   pixel_word [31:0]
//  output    out        out_valid / out_stall hwba_word  [30:0]
//
// One word is accepted per clock while in_stall is low.
// The pipeline is sector selection, scaling, scale estimate, six restoring
// division steps for the hue fraction, and the output register.
// Each stage moves when its successor is empty or moving, so bubbles close up.
// in_stall is high only when every stage holds a word and out_stall is high.
// Reset clears the valid bits only.
module rgba_to_hwba_convert
    import r2h_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [PIX_W-1:0]    pixel_word,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [HWBA_W-1:0]   hwba_word
);

    localparam int NSTG = QUO_W + 4;
    localparam int DIV0 = 3;

    logic [NSTG-1:0] pipe_v;
    logic [NSTG-1:0] pipe_en;

    // Stage 1.
    logic [CHAN_W-1:0] red, green, blue, alpha_in;
    logic [CHAN_W-1:0] mx_next, mn_next, c_next, n_next;
    logic [HUE_W-1:0]  base_next;
    logic              s1_valid_reg;
    logic [CHAN_W-1:0] s1_mx_reg, s1_mn_reg, s1_c_reg, s1_n_reg, s1_alpha_reg;
    logic [HUE_W-1:0]  s1_base_reg;

    // Stage 2.
    logic [REM_W-1:0]  dividend_next;
    logic [DVS_W-1:0]  divisor_next;
    logic [SCL_W:0]    white_raw, black_raw;
    logic [CHAN_W-1:0] inv_mx;
    logic              s2_valid_reg;
    logic [REM_W-1:0]  s2_dividend_reg;
    logic [DVS_W-1:0]  s2_divisor_reg;
    logic [SCL_W-1:0]  s2_white_reg, s2_black_reg;
    logic              s2_grey_reg;
    logic [HUE_W-1:0]  s2_base_reg;
    logic [CHAN_W-1:0] s2_alpha_reg;

    // Stage 3.
    logic [SCL_W+7:0]  white_prod, black_prod;
    logic              s3_valid_reg;
    div_t              s3_reg;
    div_t              s3_next;

    div_t              dchain [0:QUO_W];
    logic [QUO_W:0]    vchain;

    // Output stage.
    logic [HUE_W-1:0]  hue;
    logic [WB_W-1:0]   white, black;
    logic [SCL_W:0]    white_rest, black_rest;
    logic [HWBA_W-1:0] word_next;
    logic              out_valid_reg;
    logic [HWBA_W-1:0] hwba_word_reg;

    always_comb
    begin
        pipe_en[NSTG-1] = !pipe_v[NSTG-1] || !out_stall;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            pipe_en[i] = !pipe_v[i] || pipe_en[i+1];
        end
    end

    assign in_stall = !pipe_en[0];

    always_comb
    begin
        red      = pixel_word[31:24];
        green    = pixel_word[23:16];
        blue     = pixel_word[15:8];
        alpha_in = pixel_word[7:0];

        mx_next = red;
        mn_next = red;
        if (green > mx_next) mx_next = green;
        if (blue > mx_next)  mx_next = blue;
        if (green < mn_next) mn_next = green;
        if (blue < mn_next)  mn_next = blue;
        c_next = mx_next - mn_next;

        if (red == mx_next)
        begin
            if (green >= blue)
            begin
                base_next = HUE_BASE_RED_UP;
                n_next    = green - blue;
            end
            else
            begin
                base_next = HUE_BASE_RED_DN;
                n_next    = c_next + green - blue;
            end
        end
        else if (green == mx_next)
        begin
            if (blue >= red)
            begin
                base_next = HUE_BASE_GREEN_UP;
                n_next    = blue - red;
            end
            else
            begin
                base_next = HUE_BASE_GREEN_DN;
                n_next    = c_next + blue - red;
            end
        end
        else
        begin
            if (red >= green)
            begin
                base_next = HUE_BASE_BLUE_UP;
                n_next    = red - green;
            end
            else
            begin
                base_next = HUE_BASE_BLUE_DN;
                n_next    = c_next + red - green;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pipe_en[0])
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en[0])
        begin
            s1_mx_reg    <= mx_next;
            s1_mn_reg    <= mn_next;
            s1_c_reg     <= c_next;
            s1_n_reg     <= n_next;
            s1_base_reg  <= base_next;
            s1_alpha_reg <= alpha_in;
        end
    end

    // The hue fraction is round(60*n/c), taken as floor((120*n + c) / (2*c)).
    always_comb
    begin
        dividend_next = REM_W'(s1_n_reg) * REM_W'(120) + REM_W'(s1_c_reg);
        divisor_next  = (s1_c_reg == '0) ? DVS_W'(1) : {s1_c_reg, 1'b0};
        inv_mx        = 8'd255 - s1_mx_reg;
        white_raw     = (SCL_W+1)'(s1_mn_reg) * (SCL_W+1)'(254) + (SCL_W+1)'(255);
        black_raw     = (SCL_W+1)'(inv_mx) * (SCL_W+1)'(254) + (SCL_W+1)'(255);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (pipe_en[1])
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en[1])
        begin
            s2_dividend_reg <= dividend_next;
            s2_divisor_reg  <= divisor_next;
            s2_white_reg    <= white_raw[SCL_W:1];
            s2_black_reg    <= black_raw[SCL_W:1];
            s2_grey_reg     <= (s1_c_reg == '0);
            s2_base_reg     <= s1_base_reg;
            s2_alpha_reg    <= s1_alpha_reg;
        end
    end

    // Division by 255 starts from a multiply by 257/65536, which is low by at most one.
    always_comb
    begin
        white_prod = {s2_white_reg, 8'd0} + (SCL_W+8)'(s2_white_reg);
        black_prod = {s2_black_reg, 8'd0} + (SCL_W+8)'(s2_black_reg);

        s3_next                = '0;
        s3_next.rem            = s2_dividend_reg;
        s3_next.dvs            = s2_divisor_reg;
        s3_next.side.grey      = s2_grey_reg;
        s3_next.side.base      = s2_base_reg;
        s3_next.side.white_scl = s2_white_reg;
        s3_next.side.white_est = white_prod[SCL_W+7:16];
        s3_next.side.black_scl = s2_black_reg;
        s3_next.side.black_est = black_prod[SCL_W+7:16];
        s3_next.side.alpha     = s2_alpha_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (pipe_en[2])
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en[2])
        begin
            s3_reg <= s3_next;
        end
    end

    assign dchain[0] = s3_reg;
    assign vchain[0] = s3_valid_reg;

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        r2h_div_stage #(
            .SHIFT(QUO_W - 1 - j)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (pipe_en[DIV0+j]),
            .valid_in (vchain[j]),
            .data_in  (dchain[j]),
            .valid_out(vchain[j+1]),
            .data_out (dchain[j+1])
        );
    end

    assign pipe_v = {out_valid_reg, vchain[QUO_W:1], s3_valid_reg, s2_valid_reg, s1_valid_reg};

    always_comb
    begin
        hue = dchain[QUO_W].side.grey ? '0
            : dchain[QUO_W].side.base + HUE_W'(dchain[QUO_W].quo);

        white_rest = (SCL_W+1)'(dchain[QUO_W].side.white_scl)
                   - (SCL_W+1)'({dchain[QUO_W].side.white_est, 8'd0})
                   + (SCL_W+1)'(dchain[QUO_W].side.white_est);
        black_rest = (SCL_W+1)'(dchain[QUO_W].side.black_scl)
                   - (SCL_W+1)'({dchain[QUO_W].side.black_est, 8'd0})
                   + (SCL_W+1)'(dchain[QUO_W].side.black_est);
        white = dchain[QUO_W].side.white_est + WB_W'(white_rest >= (SCL_W+1)'(255));
        black = dchain[QUO_W].side.black_est + WB_W'(black_rest >= (SCL_W+1)'(255));

        if (dchain[QUO_W].side.alpha == '0)
        begin
            word_next = '0;
        end
        else
        begin
            word_next = {hue, white, black, dchain[QUO_W].side.alpha};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pipe_en[NSTG-1])
        begin
            out_valid_reg <= vchain[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en[NSTG-1])
        begin
            hwba_word_reg <= word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hwba_word = hwba_word_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hwba_word[30:22] <= HUE_MAX))
        else $error("hue above 360 degrees");

    // Whiteness and blackness come from min and 255-max, whose sum is at most 255.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (hwba_word[7:0] != '0))
            |-> ((8'(hwba_word[21:15]) + 8'(hwba_word[14:8])) <= 8'd127))
        else $error("whiteness plus blackness above full scale");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&pipe_v))
        else $error("input stalled while the pipeline has a free stage");

endmodule

FILE: sim/rgba_to_hwba_convert_tb.sv
// Self-checking testbench for the RGBA to HWBA converter: handshake stimulus and word checking.
module rgba_to_hwba_convert_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import r2h_pkg::*;

    localparam int RANDOM_WORDS   = 520;
    localparam int PRESSURE_WORDS = 60;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef enum int {RX_FREE, RX_COIN, RX_HEAVY, RX_EVERY_FOURTH} stall_mode_t;

    class hwba_ledger;
        logic [HWBA_W-1:0] expected_hwba[$];
        int                mismatches;

        task report(string msg);
            $display("%0t ns: %s", $time, msg);
            mismatches++;
        endtask

        function logic [HWBA_W-1:0] hwba_of(logic [PIX_W-1:0] px);
            int red;
            int green;
            int blue;
            int alpha;
            int top;
            int bottom;
            int chroma;
            int num;
            int hue;
            int white;
            int black;
            red   = int'(px[31:24]);
            green = int'(px[23:16]);
            blue  = int'(px[15:8]);
            alpha = int'(px[7:0]);
            if (alpha == 0)
            begin
                return '0;
            end
            top    = red;
            bottom = red;
            if (green > top) top = green;
            if (blue > top) top = blue;
            if (green < bottom) bottom = green;
            if (blue < bottom) bottom = blue;
            chroma = top - bottom;
            if (chroma == 0)
            begin
                hue = 0;
            end
            else
            begin
                if (red == top)
                begin
                    num = 60 * (green - blue);
                    if (num < 0) num += 360 * chroma;
                end
                else if (green == top)
                begin
                    num = 60 * (blue - red) + 120 * chroma;
                end
                else
                begin
                    num = 60 * (red - green) + 240 * chroma;
                end
                hue = (2 * num + chroma) / (2 * chroma);
            end
            white = (254 * bottom + 255) / 510;
            black = (254 * (255 - top) + 255) / 510;
            return {hue[8:0], white[6:0], black[6:0], alpha[7:0]};
        endfunction

        function void note_pixel(logic [PIX_W-1:0] px);
            expected_hwba.push_back(hwba_of(px));
        endfunction

        task check_hwba(logic [HWBA_W-1:0] got);
            logic [HWBA_W-1:0] want;
            if (expected_hwba.size() == 0)
            begin
                report($sformatf("unexpected word %h", got));
            end
            else
            begin
                want = expected_hwba.pop_front();
                if (got !== want)
                begin
                    report($sformatf({"hwba_word %h (h %0d w %0d b %0d a %0d), ",
                                      "expected %h (h %0d w %0d b %0d a %0d)"},
                        got, got[30:22], got[21:15], got[14:8], got[7:0],
                        want, want[30:22], want[21:15], want[14:8], want[7:0]));
                end
            end
        endtask

        function int pending();
            return expected_hwba.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [PIX_W-1:0]   pixel_word;
    logic               out_valid;
    logic               out_stall;
    logic [HWBA_W-1:0]  hwba_word;
    logic               hold_req;
    int                 idle_cycles;
    int                 burst_left;
    hwba_ledger         ledger;

    rgba_to_hwba_convert DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_word (pixel_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hwba_word  (hwba_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic offer_pixel(input logic [PIX_W-1:0] px);
        in_valid   <= 1'b1;
        pixel_word <= px;
        do @(posedge clk); while (in_stall);
        ledger.note_pixel(px);
    endtask

    task automatic offer_in_bursts(input logic [PIX_W-1:0] px);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid   <= 1'b0;
                pixel_word <= $urandom;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        offer_pixel(px);
    endtask

    function automatic logic [PIX_W-1:0] random_pixel();
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        red   = 8'($urandom);
        green = 8'($urandom);
        blue  = 8'($urandom);
        alpha = 8'($urandom);
        case ($urandom_range(0, 9))
            0: alpha = 8'd0;
            1:
            begin
                green = red;
                blue  = red;
            end
            2:
            begin
                // Red on top with blue above green lands the hue in the sector that ends at the wrap.
                red   = 8'($urandom_range(2, 255));
                blue  = 8'($urandom_range(1, red));
                green = 8'($urandom_range(0, blue - 1));
            end
            3: green = ($urandom_range(0, 1) == 1) ? red : blue;
            default: ;
        endcase
        return {red, green, blue, alpha};
    endfunction

    initial
    begin
        logic [PIX_W-1:0] directed[$];
        ledger     = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        pixel_word = '0;
        hold_req   = 1'b0;
        burst_left = 0;
        directed = '{32'h00000000, 32'hFFFFFF00, 32'h12345600, 32'hFFFFFFFF,
                     32'h000000FF, 32'h80808080, 32'hFFFFFF01, 32'hFF0000FF,
                     32'h00FF00FF, 32'h0000FFFF, 32'hFFFF00FF, 32'h00FFFFFF,
                     32'hFF00FFFF, 32'hFF0001FF, 32'hFE0001FF, 32'hFF0102FF,
                     32'h01000001, 32'h00010080, 32'h0100007F, 32'hFF8000FF,
                     32'h80FF0040, 32'h0080FF10, 32'h7F7F8120, 32'h0000017E,
                     32'hFFFFFE55};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i]) offer_in_bursts(directed[i]);
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS / 2)
            begin
                hold_req <= 1'b1;
                repeat (PRESSURE_WORDS) offer_pixel(random_pixel());
                burst_left = 0;
            end
            offer_in_bursts(random_pixel());
        end
        in_valid <= 1'b0;
        while (ledger.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ledger.pending() != 0)
        begin
            ledger.report($sformatf("%0d words never came out", ledger.pending()));
        end
        if (ledger.mismatches == 0)
        begin
            $display("rgba_to_hwba_convert_tb: clean");
        end
        else
        begin
            $display("rgba_to_hwba_convert_tb: errors");
        end
        $finish;
    end

    initial
    begin
        stall_mode_t mode;
        int          mode_left;
        int          hold_left;
        int          cycle;
        logic        hold_prev;
        mode      = RX_FREE;
        mode_left = 0;
        hold_left = 0;
        cycle     = 0;
        hold_prev = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            cycle++;
            if (hold_req && !hold_prev) hold_left = HOLD_CYCLES;
            hold_prev = hold_req;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = stall_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    RX_FREE:         out_stall <= 1'b0;
                    RX_COIN:         out_stall <= 1'($urandom_range(0, 1));
                    RX_HEAVY:        out_stall <= ($urandom_range(0, 3) != 0);
                    RX_EVERY_FOURTH: out_stall <= (cycle % 4 == 0);
                    default:         out_stall <= 1'b0;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            ledger.check_hwba(hwba_word);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("rgba_to_hwba_convert_tb: errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
